/* rtl/sha1md_pkg.sv */
// Shared types and constants for the SHA-1 message digest block.
package sha1md_pkg;

    // Depth of the queue between intake and the compression engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Compression schedule.
    localparam int ROUNDS       = 80;
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int BLOCK_WORDS  = 16;
    localparam int CHAIN_WORDS  = 5;
    localparam int DIGEST_IDX_W = 3;

    // Padding: the length field needs the last 64 bits of a block.
    localparam int          PAD_LIMIT_BITS  = 448;
    localparam int          PAD_LIMIT_BYTES = PAD_LIMIT_BITS / 8;
    localparam logic [7:0]  PAD_BYTE        = 8'o200;

    // Round constants.
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // One queued item after classification.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
    } t_item;

    // Initial chaining value for word idx.
    function automatic logic [31:0] init_word(input logic [DIGEST_IDX_W-1:0] idx);
        logic [31:0] v;
        v = 32'h67452301;
        unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hC3D2E1F0;
            default: v = 32'h67452301;
        endcase
        return v;
    endfunction

endpackage

/* rtl/sha1md_intake.sv */
// Intake stage: drops empty items and queues the rest for the engine.
module sha1md_intake
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_message_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output t_item       o_item,
    output logic        o_item_valid,
    input  logic        i_item_ready
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    // An item with neither a byte nor an end mark changes nothing, so it is not queued.
    assign o_stall      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push         = i_valid && !o_stall && (i_byte_valid || i_end_of_message);
    assign o_item_valid = (r_count != '0);
    assign pop          = o_item_valid && i_item_ready;
    assign o_item       = r_mem[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{data: i_message_byte, has_byte: i_byte_valid,
                                 eom: i_end_of_message};
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/sha1md_core.sv */
// Engine: packs bytes, pads, runs the 80-round compression and emits the digest.
module sha1md_core
    import sha1md_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_item                   i_item,
    input  logic                    i_item_valid,
    output logic                    o_item_ready,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [31:0]             o_digest_word,
    output logic [DIGEST_IDX_W-1:0] o_word_index,
    output logic                    o_last_word
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROUND = 6'b000010,
        S_FIN   = 6'b000100,
        S_PAD   = 6'b001000,
        S_LEN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                  r_state;
    t_state                  r_after;
    logic [31:0]             r_w     [BLOCK_WORDS];
    logic [31:0]             r_chain [CHAIN_WORDS];
    logic [31:0]             r_a, r_b, r_c, r_d, r_e;
    logic [63:0]             r_bit_count;
    logic [ROUND_W-1:0]      r_round;
    logic [DIGEST_IDX_W-1:0] r_idx;

    logic [31:0]             n_w_byte [BLOCK_WORDS];
    logic [31:0]             n_w_pad  [BLOCK_WORDS];
    logic [31:0]             n_w_len  [BLOCK_WORDS];
    logic [5:0]              pos;
    logic [3:0]              widx;
    logic                    pos_high;
    logic [31:0]             f;
    logic [31:0]             k;
    logic [31:0]             t_sum;
    logic [31:0]             w_next;

    assign pos      = r_bit_count[8:3];
    assign widx     = pos[5:2];
    assign pos_high = (pos >= 6'(PAD_LIMIT_BYTES));

    assign o_item_ready  = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_chain[0];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == DIGEST_IDX_W'(CHAIN_WORDS - 1));

    // Block buffer with the incoming byte placed at the fill position, big-endian.
    always_comb begin
        for (int j = 0; j < BLOCK_WORDS; j++) begin
            n_w_byte[j] = r_w[j];
            if (4'(j) == widx) begin
                unique case (pos[1:0])
                    2'd0: n_w_byte[j][31:24] = i_item.data;
                    2'd1: n_w_byte[j][23:16] = i_item.data;
                    2'd2: n_w_byte[j][15:8]  = i_item.data;
                    2'd3: n_w_byte[j][7:0]   = i_item.data;
                endcase
            end
        end
    end

    // Padding: the marker byte, zeros after it, and the length when it fits.
    always_comb begin
        for (int j = 0; j < BLOCK_WORDS; j++) begin
            if (4'(j) < widx) begin
                n_w_pad[j] = r_w[j];
            end else if (4'(j) == widx) begin
                unique case (pos[1:0])
                    2'd0: n_w_pad[j] = {PAD_BYTE, 24'h0};
                    2'd1: n_w_pad[j] = {r_w[j][31:24], PAD_BYTE, 16'h0};
                    2'd2: n_w_pad[j] = {r_w[j][31:16], PAD_BYTE, 8'h0};
                    2'd3: n_w_pad[j] = {r_w[j][31:8], PAD_BYTE};
                endcase
            end else begin
                n_w_pad[j] = '0;
            end
            if (!pos_high && j == BLOCK_WORDS - 2) begin
                n_w_pad[j] = r_bit_count[63:32];
            end
            if (!pos_high && j == BLOCK_WORDS - 1) begin
                n_w_pad[j] = r_bit_count[31:0];
            end
        end
    end

    // Extra length-only block when the padding overflowed into a second block.
    always_comb begin
        for (int j = 0; j < BLOCK_WORDS; j++) begin
            n_w_len[j] = '0;
        end
        n_w_len[BLOCK_WORDS-2] = r_bit_count[63:32];
        n_w_len[BLOCK_WORDS-1] = r_bit_count[31:0];
    end

    // Round function and message schedule; the window's head is the current word.
    always_comb begin
        priority if (r_round < ROUND_W'(20)) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = K_0;
        end else if (r_round < ROUND_W'(40)) begin
            f = r_b ^ r_c ^ r_d;
            k = K_1;
        end else if (r_round < ROUND_W'(60)) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K_2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K_3;
        end
        t_sum  = {r_a[26:0], r_a[31:27]} + f + r_e + k + r_w[0];
        w_next = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_next = {w_next[30:0], w_next[31]};
    end

    // Block buffer and working variables carry no reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && i_item.has_byte) begin
                    r_w <= n_w_byte;
                end
                r_a <= r_chain[0];
                r_b <= r_chain[1];
                r_c <= r_chain[2];
                r_d <= r_chain[3];
                r_e <= r_chain[4];
            end
            S_ROUND: begin
                r_a <= t_sum;
                r_b <= r_a;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_d <= r_c;
                r_e <= r_d;
                for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
                    r_w[j] <= r_w[j+1];
                end
                r_w[BLOCK_WORDS-1] <= w_next;
            end
            S_PAD: begin
                r_w <= n_w_pad;
                r_a <= r_chain[0];
                r_b <= r_chain[1];
                r_c <= r_chain[2];
                r_d <= r_chain[3];
                r_e <= r_chain[4];
            end
            S_LEN: begin
                r_w <= n_w_len;
                r_a <= r_chain[0];
                r_b <= r_chain[1];
                r_c <= r_chain[2];
                r_d <= r_chain[3];
                r_e <= r_chain[4];
            end
            default: begin
            end
        endcase
    end

    // Sequencer, chaining words and length count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_bit_count <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            for (int j = 0; j < CHAIN_WORDS; j++) begin
                r_chain[j] <= init_word(DIGEST_IDX_W'(j));
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_round <= '0;
                        if (i_item.has_byte) begin
                            r_bit_count <= r_bit_count + 64'd8;
                        end
                        // A byte in the last slot fills the block and starts a compression.
                        if (i_item.has_byte && pos == 6'h3F) begin
                            r_state <= S_ROUND;
                            r_after <= i_item.eom ? S_PAD : S_IDLE;
                        end else if (i_item.eom) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 1'b1;
                    if (r_round == ROUND_W'(ROUNDS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_chain[4] <= r_chain[4] + r_e;
                    r_idx      <= '0;
                    r_state    <= r_after;
                end
                S_PAD: begin
                    r_round <= '0;
                    r_state <= S_ROUND;
                    r_after <= pos_high ? S_LEN : S_OUT;
                end
                S_LEN: begin
                    r_round <= '0;
                    r_state <= S_ROUND;
                    r_after <= S_OUT;
                end
                S_OUT: begin
                    // Shift the digest out and refill the chain with initial values.
                    if (!i_stall) begin
                        for (int j = 0; j < CHAIN_WORDS - 1; j++) begin
                            r_chain[j] <= r_chain[j+1];
                        end
                        r_chain[CHAIN_WORDS-1] <= init_word(r_idx);
                        if (o_last_word) begin
                            r_idx       <= '0;
                            r_bit_count <= '0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/sha1_message_digest.sv */
// Top level of the SHA-1 message digest block.
//
// Input channel (i_valid / o_stall): one transfer per message item carrying a
// byte (i_byte_valid) and an end mark (i_end_of_message). Items with neither
// are dropped. Accepted items enter a four-entry queue, so intake continues
// while the engine compresses or the digest waits on the output.
// The engine takes queued bytes while idle; a full 64-byte block then runs
// 80 rounds and the chaining add, during which no item is taken; a single
// round adder serves every round. On the end mark the engine pads and runs
// one compression, or two when fewer than nine bytes remain in the block
// (S_LEN loads the length-only block). The first digest word follows the
// last compression; when the end item's own byte fills the block, that
// block is compressed before the padding block.
// Output channel (o_valid / i_stall): five transfers of a 32-bit word, index
// 0 first, o_last_word on index 4, at most one per cycle. A stalled word is
// held; the engine waits and the queue keeps taking items until full.
// Reset (synchronous, active low) empties the queue, loads the initial
// chaining value and clears the bit count.
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_message_byte,
    input  logic                    i_byte_valid,
    input  logic                    i_end_of_message,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [31:0]             o_digest_word,
    output logic [DIGEST_IDX_W-1:0] o_word_index,
    output logic                    o_last_word
);

    t_item item;
    logic  item_valid;
    logic  item_ready;

    // Intake and queue.
    sha1md_intake u_intake (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_message_byte   (i_message_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_item           (item),
        .o_item_valid     (item_valid),
        .i_item_ready     (item_ready)
    );

    // Compression engine and digest output.
    sha1md_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item),
        .i_item_valid  (item_valid),
        .o_item_ready  (item_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

/* rtl/sha1md_checker.sv */
// Port-level checks for the SHA-1 message digest block, bound to the top level.
module sha1md_checker
    import sha1md_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [31:0]             o_digest_word,
    input logic [DIGEST_IDX_W-1:0] o_word_index,
    input logic                    o_last_word
);

    // A stalled digest word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("digest word changed while stalled");

    // Words follow one another in index order.
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_word |=>
            o_valid && o_word_index == DIGEST_IDX_W'($past(o_word_index) + 1'b1))
        else $error("digest word index did not advance by one");

    // The last mark sits on the fifth word only.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == DIGEST_IDX_W'(CHAIN_WORDS - 1))))
        else $error("last-word mark on the wrong index");

    // The index never goes past the fifth word.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_word_index <= DIGEST_IDX_W'(CHAIN_WORDS - 1))
        else $error("digest word index out of range");

    // A digest is never followed at once by another word.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_word |=> !o_valid)
        else $error("output continued after the last digest word");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
